// ===== rtl/core/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the CMake token scanner: scan modes, token
// kinds, byte codes and the token record that travels to the output queue.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned MAX_EQUALS_DEF  = 255;

  // Fixed field widths of a token record
  localparam int unsigned START_W = 24;
  localparam int unsigned LEN_W   = 25;
  localparam int unsigned LINE_W  = 25;
  localparam int unsigned COL_W   = 25;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned BYTE_W  = 8;

  // Result packing: kind, start, length, line, column, zero pad to bytes
  localparam int unsigned REC_BITS   = KIND_W + START_W + LEN_W + LINE_W + COL_W;
  localparam int unsigned OUT_DATA_W = ((REC_BITS + 7) / 8) * 8;

  // Output queue depth and its fill count width
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Byte codes
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D;

  typedef enum logic [3:0] {
    M_IDLE, M_SPACE, M_CR, M_HASH, M_HASH_EQ, M_LINE, M_QUOTED, M_LBR_EQ,
    M_UNQ, M_BC_BODY, M_BC_CLOSE, M_BA_BODY, M_BA_CLOSE
  } scan_mode_e;

  typedef enum logic [KIND_W-1:0] {
    K_EOF             = 4'd0,
    K_SPACE           = 4'd1,
    K_NEWLINE         = 4'd2,
    K_LPAREN          = 4'd3,
    K_RPAREN          = 4'd4,
    K_LINE_COMMENT    = 4'd5,
    K_BRACKET_COMMENT = 4'd6,
    K_QUOTED          = 4'd7,
    K_BRACKET_ARG     = 4'd8,
    K_UNQUOTED        = 4'd9,
    K_ERR_STRING      = 4'd10,
    K_ERR_BRACKET     = 4'd11
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e                 kind;
    logic [START_W-1:0]        start;
    logic [LEN_W-1:0]          length;
    logic [LINE_W-1:0]         line;
    logic signed [COL_W-1:0]   column;
    logic                      last;
  } tok_rec_t;

  // Records produced by one accepted beat
  typedef struct packed {
    logic [1:0] cnt;
    tok_rec_t   first;
    tok_rec_t   second;
  } tok_push_t;

endpackage

// ===== rtl/core/cts_scan.sv =====
// ----------------------------------------------------------------------------
// cts_scan
// Scanner state and the single-pass next-state logic: one source byte or the
// end marker per accepted beat, zero to two finished token records out.
// ----------------------------------------------------------------------------
module cts_scan #(
  parameter int unsigned OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF,
  parameter int unsigned MAX_EQUALS  = cts_pkg::MAX_EQUALS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [cts_pkg::BYTE_W-1:0] byte_i,
  input  logic                       eot_i,
  output cts_pkg::tok_push_t         push_o
);
  import cts_pkg::*;

  localparam int unsigned EQ_W = $clog2(MAX_EQUALS + 1);

  scan_mode_e             mode_q, mode_d;
  logic [EQ_W-1:0]        oe_q, oe_d;
  logic [EQ_W-1:0]        ce_q, ce_d;
  logic [OFFSET_BITS-1:0] so_q, so_d;
  logic [OFFSET_BITS-1:0] bo_q, bo_d;
  logic [LINE_W-1:0]      ln_q, ln_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic                   esc_q, esc_d;

  logic     done;
  logic     e1_vld, e2_vld;
  tok_rec_t e1_rec, e2_rec;

  function automatic logic [EQ_W-1:0] sat_inc(input logic [EQ_W-1:0] v);
    logic [EQ_W-1:0] r;
    if (v >= EQ_W'(MAX_EQUALS)) r = EQ_W'(MAX_EQUALS);
    else r = v + EQ_W'(1);
    return r;
  endfunction

  function automatic tok_rec_t mk_rec(input tok_kind_e k,
                                      input logic [OFFSET_BITS-1:0] so,
                                      input logic [OFFSET_BITS-1:0] bo,
                                      input logic [LINE_W-1:0] ln,
                                      input logic [COL_W-1:0] col);
    tok_rec_t                       r;
    logic [OFFSET_BITS-1:0]         len;
    logic [OFFSET_BITS+LEN_W-1:0]   len_x;
    logic [OFFSET_BITS+START_W-1:0] st_x;
    len      = bo - so;
    len_x    = {{LEN_W{1'b0}}, len};
    st_x     = {{START_W{1'b0}}, so};
    r.kind   = k;
    r.start  = st_x[START_W-1:0];
    r.length = len_x[LEN_W-1:0];
    r.line   = ln;
    r.column = col - len_x[LEN_W-1:0];
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic tok_rec_t mk_err(input tok_kind_e k,
                                      input logic [OFFSET_BITS-1:0] so,
                                      input logic [LINE_W-1:0] ln,
                                      input logic [COL_W-1:0] col);
    tok_rec_t                       r;
    logic [OFFSET_BITS+START_W-1:0] st_x;
    st_x     = {{START_W{1'b0}}, so};
    r.kind   = k;
    r.start  = st_x[START_W-1:0];
    r.length = '0;
    r.line   = ln;
    r.column = col;
    r.last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_d = mode_q;
    oe_d   = oe_q;
    ce_d   = ce_q;
    so_d   = so_q;
    bo_d   = bo_q;
    ln_d   = ln_q;
    col_d  = col_q;
    esc_d  = esc_q;
    done   = 1'b0;
    e1_vld = 1'b0;
    e2_vld = 1'b0;
    e1_rec = '0;
    e2_rec = '0;

    if (accept_i && eot_i) begin
      // close the pending token, then the eof record
      unique case (mode_q)
        M_SPACE: begin
          e1_vld = 1'b1;
          e1_rec = mk_rec(K_SPACE, so_q, bo_q, ln_q, col_q);
        end
        M_CR, M_LBR_EQ, M_UNQ: begin
          e1_vld = 1'b1;
          e1_rec = mk_rec(K_UNQUOTED, so_q, bo_q, ln_q, col_q);
        end
        M_HASH, M_HASH_EQ, M_LINE: begin
          e1_vld = 1'b1;
          e1_rec = mk_rec(K_LINE_COMMENT, so_q, bo_q, ln_q, col_q);
        end
        M_QUOTED: begin
          e1_vld = 1'b1;
          e1_rec = mk_err(K_ERR_STRING, so_q, ln_q, col_q);
        end
        M_BC_BODY, M_BC_CLOSE, M_BA_BODY, M_BA_CLOSE: begin
          e1_vld = 1'b1;
          e1_rec = mk_err(K_ERR_BRACKET, so_q, ln_q, col_q);
        end
        default: ;
      endcase
      mode_d = M_IDLE;
      esc_d  = 1'b0;
      so_d   = bo_q;
      e2_vld = 1'b1;
      e2_rec = mk_rec(K_EOF, bo_q, bo_q, ln_q, col_q);
    end else if (accept_i) begin
      // first: modes that consume the byte or hand it to another mode
      unique case (mode_d)
        M_CR: begin
          if (byte_i == CH_LF) begin
            bo_d   = bo_d + 1'b1;
            ln_d   = ln_d + 1'b1;
            col_d  = COL_W'(1);
            e1_vld = 1'b1;
            e1_rec = mk_rec(K_NEWLINE, so_d, bo_d, ln_d, col_d);
            mode_d = M_IDLE;
            done   = 1'b1;
          end else begin
            mode_d = M_UNQ;
            esc_d  = 1'b0;
          end
        end
        M_HASH: begin
          if (byte_i == CH_LBR) begin
            bo_d   = bo_d + 1'b1;
            col_d  = col_d + 1'b1;
            oe_d   = '0;
            mode_d = M_HASH_EQ;
            done   = 1'b1;
          end else begin
            mode_d = M_LINE;
          end
        end
        M_HASH_EQ, M_LBR_EQ: begin
          if (byte_i == CH_EQ) begin
            bo_d  = bo_d + 1'b1;
            col_d = col_d + 1'b1;
            oe_d  = sat_inc(oe_d);
            done  = 1'b1;
          end else if (byte_i == CH_LBR) begin
            bo_d   = bo_d + 1'b1;
            col_d  = col_d + 1'b1;
            mode_d = (mode_q == M_HASH_EQ) ? M_BC_BODY : M_BA_BODY;
            done   = 1'b1;
          end else if (mode_q == M_HASH_EQ) begin
            mode_d = M_LINE;
          end else begin
            mode_d = M_UNQ;
            esc_d  = 1'b0;
          end
        end
        M_BC_CLOSE, M_BA_CLOSE: begin
          if (byte_i == CH_EQ) begin
            bo_d  = bo_d + 1'b1;
            col_d = col_d + 1'b1;
            ce_d  = sat_inc(ce_d);
            done  = 1'b1;
          end else if (byte_i == CH_RBR) begin
            bo_d  = bo_d + 1'b1;
            col_d = col_d + 1'b1;
            if (ce_d == oe_d) begin
              e1_vld = 1'b1;
              e1_rec = mk_rec((mode_q == M_BC_CLOSE) ? K_BRACKET_COMMENT : K_BRACKET_ARG,
                              so_d, bo_d, ln_d, col_d);
              mode_d = M_IDLE;
            end else begin
              ce_d = '0;
            end
            done = 1'b1;
          end else begin
            mode_d = (mode_q == M_BC_CLOSE) ? M_BC_BODY : M_BA_BODY;
          end
        end
        default: ;
      endcase

      // second: modes that either take the byte or end their token
      if (!done) begin
        unique case (mode_d)
          M_SPACE: begin
            if (byte_i == CH_SP || byte_i == CH_TAB) begin
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
              done  = 1'b1;
            end else begin
              e1_vld = 1'b1;
              e1_rec = mk_rec(K_SPACE, so_d, bo_d, ln_d, col_d);
              mode_d = M_IDLE;
            end
          end
          M_LINE: begin
            if (byte_i == CH_LF) begin
              e1_vld = 1'b1;
              e1_rec = mk_rec(K_LINE_COMMENT, so_d, bo_d, ln_d, col_d);
              mode_d = M_IDLE;
            end else begin
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
              done  = 1'b1;
            end
          end
          M_QUOTED: begin
            done = 1'b1;
            if (esc_d && byte_i == CH_QUOTE) begin
              esc_d = 1'b0;
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
            end else if (byte_i == CH_QUOTE) begin
              bo_d   = bo_d + 1'b1;
              col_d  = col_d + 1'b1;
              e1_vld = 1'b1;
              e1_rec = mk_rec(K_QUOTED, so_d, bo_d, ln_d, col_d);
              mode_d = M_IDLE;
              esc_d  = 1'b0;
            end else begin
              // a newline restarts the column, then the byte advances it
              if (byte_i == CH_LF) begin
                ln_d  = ln_d + 1'b1;
                col_d = COL_W'(1);
              end
              esc_d = (byte_i == CH_BSL);
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
            end
          end
          M_UNQ: begin
            if (esc_d) begin
              esc_d = 1'b0;
              if (byte_i == CH_LF) begin
                ln_d  = ln_d + 1'b1;
                col_d = COL_W'(1);
              end
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
              done  = 1'b1;
            end else if (byte_i == CH_SP || byte_i == CH_TAB || byte_i == CH_LF ||
                         byte_i == CH_CR || byte_i == CH_LPAR || byte_i == CH_RPAR ||
                         byte_i == CH_HASH || byte_i == CH_QUOTE) begin
              e1_vld = 1'b1;
              e1_rec = mk_rec(K_UNQUOTED, so_d, bo_d, ln_d, col_d);
              mode_d = M_IDLE;
            end else begin
              esc_d = (byte_i == CH_BSL);
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
              done  = 1'b1;
            end
          end
          M_BC_BODY, M_BA_BODY: begin
            done = 1'b1;
            if (byte_i == CH_LF) begin
              // a newline resets the column to one inside a bracket body
              ln_d  = ln_d + 1'b1;
              col_d = COL_W'(1);
              bo_d  = bo_d + 1'b1;
            end else if (byte_i == CH_RBR) begin
              bo_d   = bo_d + 1'b1;
              col_d  = col_d + 1'b1;
              ce_d   = '0;
              mode_d = (mode_d == M_BC_BODY) ? M_BC_CLOSE : M_BA_CLOSE;
            end else begin
              bo_d  = bo_d + 1'b1;
              col_d = col_d + 1'b1;
            end
          end
          default: ;
        endcase
      end

      // third: the byte opens a new token
      if (!done) begin
        mode_d = M_IDLE;
        esc_d  = 1'b0;
        so_d   = bo_d;
        bo_d   = bo_d + 1'b1;
        col_d  = col_d + 1'b1;
        unique case (byte_i)
          CH_SP, CH_TAB: mode_d = M_SPACE;
          CH_LF: begin
            ln_d   = ln_d + 1'b1;
            col_d  = COL_W'(1);
            e2_vld = 1'b1;
            e2_rec = mk_rec(K_NEWLINE, so_d, bo_d, ln_d, col_d);
          end
          CH_CR: mode_d = M_CR;
          CH_LPAR: begin
            e2_vld = 1'b1;
            e2_rec = mk_rec(K_LPAREN, so_d, bo_d, ln_d, col_d);
          end
          CH_RPAR: begin
            e2_vld = 1'b1;
            e2_rec = mk_rec(K_RPAREN, so_d, bo_d, ln_d, col_d);
          end
          CH_HASH:  mode_d = M_HASH;
          CH_QUOTE: mode_d = M_QUOTED;
          CH_LBR: begin
            oe_d   = '0;
            mode_d = M_LBR_EQ;
          end
          default: mode_d = M_UNQ;
        endcase
      end
    end
  end

  // pack the records in order, mark the final one of this beat
  always_comb begin
    push_o        = '0;
    push_o.cnt    = {1'b0, e1_vld} + {1'b0, e2_vld};
    push_o.first  = e1_vld ? e1_rec : e2_rec;
    push_o.second = e2_rec;
    push_o.first.last  = !(e1_vld && e2_vld);
    push_o.second.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      oe_q   <= '0;
      ce_q   <= '0;
      so_q   <= '0;
      bo_q   <= '0;
      ln_q   <= LINE_W'(1);
      col_q  <= COL_W'(1);
      esc_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      oe_q   <= oe_d;
      ce_q   <= ce_d;
      so_q   <= so_d;
      bo_q   <= bo_d;
      ln_q   <= ln_d;
      col_q  <= col_d;
      esc_q  <= esc_d;
    end
  end

`ifndef SYNTHESIS
  a_eot_ends_with_eof : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eot_i) |->
      ((push_o.cnt == 2'd1 && push_o.first.kind == K_EOF) ||
       (push_o.cnt == 2'd2 && push_o.second.kind == K_EOF)))
    else $error("end marker did not close with an eof record");

  a_idle_one_rec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !eot_i && mode_q == M_IDLE) |-> (push_o.cnt != 2'd2))
    else $error("idle scanner produced two records for one byte");

  a_no_push_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |-> (push_o.cnt == 2'd0 && mode_d == mode_q && bo_d == bo_q))
    else $error("scanner state moved without an accepted beat");
`endif

endmodule

// ===== rtl/core/cts_outq.sv =====
// ----------------------------------------------------------------------------
// cts_outq
// Small shift queue of finished token records: takes up to two records per
// cycle while room_o is high, presents the head as the result beat.
// ----------------------------------------------------------------------------
module cts_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cts_pkg::tok_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output cts_pkg::tok_rec_t  head_o
);
  import cts_pkg::*;

  tok_rec_t          slot_q [QDEPTH];
  tok_rec_t          slot_d [QDEPTH];
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [QCNT_W-1:0] base;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign head_o  = slot_q[0];
  assign base    = cnt_q - QCNT_W'(pop);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      // advance toward the head on a pop, then drop new records behind
      if (pop && (i + 1 < QDEPTH)) slot_d[i] = slot_q[i + 1];
      else slot_d[i] = slot_q[i];
      if (push_i.cnt != 2'd0 && QCNT_W'(i) == base) slot_d[i] = push_i.first;
      if (push_i.cnt == 2'd2 && QCNT_W'(i) == base + QCNT_W'(1)) slot_d[i] = push_i.second;
    end
    cnt_d = base + QCNT_W'(push_i.cnt);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) slot_q[i] <= slot_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("record queue overfilled");

  a_push_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("records pushed without room");

  a_drain_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == QCNT_W'(1) && push_i.cnt == 2'd0) |=> !valid_o)
    else $error("queue still valid after last record left");
`endif

endmodule

// ===== rtl/core/cmake_token_scanner.sv =====
// ----------------------------------------------------------------------------
// cmake_token_scanner
// Streaming CMake lexer: source bytes in, token records out.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat content                              Beats per item
//  -------  ---  ----------------------------------------  --------------
//  s_axis   in   tdata[7:0] source byte, tlast end marker  1
//  m_axis   out  tdata token record, tlast last of item    0, 1 or 2
//
// Flow: a source beat is taken in the cycle it arrives while there is room,
// and its records are registered into the output queue, so a result beat can
// appear in the cycle after the beat that finished the token. One beat per
// cycle is taken as long as the four-entry record queue holds at most two
// records; a beat that finishes two tokens (a lookahead byte that is a token,
// or the end marker after an open token) gives two records the queue absorbs.
// Reset: rst_ni clears the scanner to idle at offset 0, line 1, column 1 and
// empties the queue; no clearing pass is needed.
// Stalls: holding m_axis_tready low fills the queue and then drops
// s_axis_tready; nothing is lost or repeated.
//
module cmake_token_scanner #(
  parameter int unsigned OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF,
  parameter int unsigned MAX_EQUALS  = cts_pkg::MAX_EQUALS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] text_byte
  input  logic                           s_axis_tlast,  // end_of_text
  // result beats
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] token_kind, [27:4] token_start, [52:28] token_length,
  // [77:53] token_line, [102:78] token_column, [103] zero
  output logic [cts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast   // last_of_item
);
  import cts_pkg::*;

  logic      accept;
  logic      room;
  tok_push_t push;
  tok_rec_t  head;

  // take a beat only while the queue can hold two more records
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cts_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_EQUALS  (MAX_EQUALS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eot_i    (s_axis_tlast),
    .push_o   (push)
  );

  cts_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  // pack the head record, kind in the lowest bits, zero pad on top
  assign m_axis_tdata = {{(OUT_DATA_W - REC_BITS){1'b0}}, head.column, head.line,
                         head.length, head.start, head.kind};
  assign m_axis_tlast = head.last;

endmodule
